FILE: sv/pap_pkg.sv
// Shared types, constants and codes for the PWM audio double-buffer player.
package pap_pkg;

    localparam int HALF_BYTES_DEF = 512;
    localparam int DUTY_FLOOR     = 30;
    localparam int SAMPLE_W       = 8;
    localparam int DUTY_W         = 16;
    localparam int TICK_W         = 16;
    localparam int WR_ADDR_W      = 10;
    localparam int START_BYTES_W  = 11;
    localparam int SKIP_W         = 3;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    // Request codes
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;
    localparam logic [1:0] REQ_HALT  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGN_FIX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BYTES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_LOG2    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_PERIOD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTES  = 3'd6;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [WR_ADDR_W-1:0] write_address;
        logic [SAMPLE_W-1:0]  write_data;
    } req_item_t;

    typedef struct packed {
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] right_duty;
        logic              refill_now;
        logic              half_to_fill;
    } res_item_t;

    // Tick in flight between the store read and the duty stage
    typedef struct packed {
        logic valid;
        logic refill_now;
        logic half_to_fill;
    } tick_info_t;

    typedef struct packed {
        logic                stereo;
        logic [SAMPLE_W-1:0] sign_fix;
        logic [DUTY_W-1:0]   scale;
    } duty_cfg_t;

endpackage

FILE: sv/pap_store.sv
// Sample byte store: one write port, two registered read ports.
module pap_store #(
    parameter int DEPTH  = 2 * pap_pkg::HALF_BYTES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [pap_pkg::SAMPLE_W-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr_a,
    input  logic [ADDR_W-1:0]            rd_addr_b,
    output logic [pap_pkg::SAMPLE_W-1:0] rd_data_a,
    output logic [pap_pkg::SAMPLE_W-1:0] rd_data_b
);
    import pap_pkg::*;

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rd_a_reg;
    logic [SAMPLE_W-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

FILE: sv/pap_duty.sv
// Duty scaling of the sample bytes and the result output register.
module pap_duty (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pap_pkg::tick_info_t          tick,
    input  logic [pap_pkg::SAMPLE_W-1:0] left_raw,
    input  logic [pap_pkg::SAMPLE_W-1:0] right_raw,
    input  pap_pkg::duty_cfg_t           cfg,
    output logic                         ready,
    output logic                         res_valid,
    input  logic                         res_stall,
    output pap_pkg::res_item_t           res
);
    import pap_pkg::*;

    localparam int PROD_W = DUTY_W + SAMPLE_W;

    logic        res_valid_reg;
    res_item_t   res_reg;
    logic [DUTY_W-1:0] left_duty;
    logic [DUTY_W-1:0] right_duty;

    function automatic logic [DUTY_W-1:0] duty_of(
        input logic [SAMPLE_W-1:0] raw,
        input logic [SAMPLE_W-1:0] sign_fix,
        input logic [DUTY_W-1:0]   scale
    );
        logic [SAMPLE_W-1:0] v;
        logic [PROD_W-1:0]   prod;
        logic [DUTY_W-1:0]   d;
        v    = raw ^ sign_fix;
        prod = PROD_W'(scale) * PROD_W'(v);
        d    = prod[PROD_W-1:SAMPLE_W] + DUTY_W'(DUTY_FLOOR);
        return d;
    endfunction

    assign left_duty  = duty_of(left_raw, cfg.sign_fix, cfg.scale);
    assign right_duty = cfg.stereo ? duty_of(right_raw, cfg.sign_fix, cfg.scale) : left_duty;

    // Output register moves when empty or when its item is taken
    assign ready = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            res_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && tick.valid)
        begin
            res_reg.left_duty    <= left_duty;
            res_reg.right_duty   <= right_duty;
            res_reg.refill_now   <= tick.refill_now;
            res_reg.half_to_fill <= tick.half_to_fill;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: sv/pwm_audio_double_buffer_player_core.sv
// PWM audio player: two-half sample store, play pointer, tick count and duty output.
// A tick's bytes are read into the store's read registers when the tick is accepted;
// the duty stage scales them into the output register when that register can move.
// Throughput: one item per cycle while the output is not stalled; both channel bytes
// come from the store's two read ports. Reset clears pointer, count, half, play state
// and configuration; the sample store is not cleared and holds unknown bytes until written.
module pwm_audio_double_buffer_player_core #(
    parameter int HALF_BYTES = pap_pkg::HALF_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  pap_pkg::req_item_t             req,
    output logic                           res_valid,
    input  logic                           res_stall,
    output pap_pkg::res_item_t             res,
    input  logic                           cfg_write,
    input  logic [pap_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pap_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pap_pkg::*;

    localparam int STORE_BYTES = 2 * HALF_BYTES;
    localparam int PTR_W       = $clog2(STORE_BYTES);
    localparam int CMP_W       = ((PTR_W > WR_ADDR_W) ? PTR_W : WR_ADDR_W) + 1;
    localparam int WRAP_STEPS  = ((1 << WR_ADDR_W) - 1) / STORE_BYTES;
    localparam logic [PTR_W-1:0]  HALF_PTR   = PTR_W'(HALF_BYTES);
    localparam logic [TICK_W-1:0] HALF_TICKS = TICK_W'(HALF_BYTES);

    // Configuration
    logic                     stereo_reg;
    logic [SAMPLE_W-1:0]      sign_fix_reg;
    logic                     eff_two_reg;
    logic [SKIP_W-1:0]        skip_reg;
    logic [DUTY_W-1:0]        scale_reg;
    logic [WR_ADDR_W-1:0]     start_offset_reg;
    logic [START_BYTES_W-1:0] start_bytes_reg;
    logic [DUTY_W-1:0]        period_scale;

    // Play state
    logic [PTR_W-1:0]  ptr_reg;
    logic [PTR_W-1:0]  ptr_next;
    logic [TICK_W-1:0] ticks_reg;
    logic [TICK_W-1:0] ticks_next;
    logic              half_reg;
    logic              half_next;
    logic              playing_reg;
    logic              playing_next;

    // Read stage
    logic s1_valid_reg;
    logic s1_valid_next;
    logic s1_refill_reg;
    logic s1_refill_next;
    logic s1_half_reg;
    logic s1_half_next;

    logic              req_acc;
    logic              tick_go;
    logic              tick_wrap;
    logic              duty_ready;
    logic [CMP_W-1:0]  wr_wide;
    logic              wr_en;
    logic [PTR_W-1:0]  rd_addr_b;
    logic [PTR_W-1:0]  ptr_step;
    logic [PTR_W:0]    skip_inc;
    logic [TICK_W-1:0] ticks_dec;
    logic [SAMPLE_W-1:0] left_raw;
    logic [SAMPLE_W-1:0] right_raw;
    tick_info_t        tick_info;
    duty_cfg_t         duty_cfg;

    function automatic logic [PTR_W-1:0] wrap_sum(input logic [PTR_W:0] sum);
        logic [PTR_W:0] lim;
        logic [PTR_W:0] r;
        lim = (PTR_W+1)'(STORE_BYTES);
        r   = (sum >= lim) ? sum - lim : sum;
        return r[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] wrap_start(input logic [WR_ADDR_W-1:0] a);
        logic [CMP_W-1:0] lim;
        logic [CMP_W-1:0] r;
        lim = CMP_W'(STORE_BYTES);
        r   = CMP_W'(a);
        for (int i = 0; i < WRAP_STEPS; i++)
        begin
            if (r >= lim)
            begin
                r = r - lim;
            end
        end
        return r[PTR_W-1:0];
    endfunction

    // ---------------------------------------------------------------- config
    assign period_scale = (cfg_data > CFG_DATA_W'(DUTY_FLOOR))
                        ? cfg_data - CFG_DATA_W'(DUTY_FLOOR) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stereo_reg       <= 1'b0;
            sign_fix_reg     <= '0;
            eff_two_reg      <= 1'b0;
            skip_reg         <= '0;
            scale_reg        <= '0;
            start_offset_reg <= '0;
            start_bytes_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_STEREO_MODE:  stereo_reg       <= cfg_data[0];
                CFG_SIGN_FIX:     sign_fix_reg     <= cfg_data[SAMPLE_W-1:0];
                // sizes 0 and 1 play as one byte, 2 and 3 as two
                CFG_SAMPLE_BYTES: eff_two_reg      <= cfg_data[1];
                CFG_SKIP_LOG2:    skip_reg         <= cfg_data[SKIP_W-1:0];
                CFG_TIMER_PERIOD: scale_reg        <= period_scale;
                CFG_START_OFFSET: start_offset_reg <= cfg_data[WR_ADDR_W-1:0];
                CFG_START_BYTES:  start_bytes_reg  <= cfg_data[START_BYTES_W-1:0];
                default:          ;
            endcase
        end
    end

    // -------------------------------------------------------------- control
    assign req_stall = s1_valid_reg && !duty_ready;
    assign req_acc   = req_valid && !req_stall;
    assign tick_go   = req_acc && (req.req_type == REQ_TICK) && playing_reg;

    assign wr_wide = CMP_W'(req.write_address);
    assign wr_en   = req_acc && (req.req_type == REQ_WRITE) && (wr_wide < CMP_W'(STORE_BYTES));

    assign skip_inc  = (PTR_W+1)'(1) << skip_reg;
    assign ptr_step  = wrap_sum({1'b0, ptr_reg} + skip_inc);
    assign rd_addr_b = wrap_sum({1'b0, ptr_reg} + (PTR_W+1)'({eff_two_reg, !eff_two_reg}));
    assign ticks_dec = ticks_reg - TICK_W'(1);
    assign tick_wrap = (ticks_dec == '0);

    always_comb
    begin
        ptr_next     = ptr_reg;
        ticks_next   = ticks_reg;
        half_next    = half_reg;
        playing_next = playing_reg;
        if (req_acc && (req.req_type == REQ_START))
        begin
            ptr_next     = wrap_start(start_offset_reg);
            ticks_next   = TICK_W'(start_bytes_reg >> skip_reg);
            half_next    = 1'b0;
            playing_next = 1'b1;
        end
        else if (req_acc && (req.req_type == REQ_HALT))
        begin
            playing_next = 1'b0;
        end
        else if (tick_go)
        begin
            if (tick_wrap)
            begin
                // swap halves, point at the first sample of the new half
                half_next  = !half_reg;
                ptr_next   = (half_reg ? '0 : HALF_PTR) + PTR_W'(eff_two_reg);
                ticks_next = HALF_TICKS >> skip_reg;
            end
            else
            begin
                ptr_next   = ptr_step;
                ticks_next = ticks_dec;
            end
        end
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_refill_next = s1_refill_reg;
        s1_half_next   = s1_half_reg;
        if (tick_go)
        begin
            s1_valid_next  = 1'b1;
            s1_refill_next = tick_wrap;
            s1_half_next   = tick_wrap ? half_reg : !half_reg;
        end
        else if (duty_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            ticks_reg     <= '0;
            half_reg      <= 1'b0;
            playing_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s1_refill_reg <= 1'b0;
            s1_half_reg   <= 1'b0;
        end
        else
        begin
            ptr_reg       <= ptr_next;
            ticks_reg     <= ticks_next;
            half_reg      <= half_next;
            playing_reg   <= playing_next;
            s1_valid_reg  <= s1_valid_next;
            s1_refill_reg <= s1_refill_next;
            s1_half_reg   <= s1_half_next;
        end
    end

    // ---------------------------------------------------------------- units
    pap_store #(
        .DEPTH  (STORE_BYTES),
        .ADDR_W (PTR_W)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_wide[PTR_W-1:0]),
        .wr_data   (req.write_data),
        .rd_en     (tick_go),
        .rd_addr_a (ptr_reg),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (left_raw),
        .rd_data_b (right_raw)
    );

    assign tick_info.valid        = s1_valid_reg;
    assign tick_info.refill_now   = s1_refill_reg;
    assign tick_info.half_to_fill = s1_half_reg;

    assign duty_cfg.stereo   = stereo_reg;
    assign duty_cfg.sign_fix = sign_fix_reg;
    assign duty_cfg.scale    = scale_reg;

    pap_duty u_duty (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_info),
        .left_raw  (left_raw),
        .right_raw (right_raw),
        .cfg       (duty_cfg),
        .ready     (duty_ready),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

`ifndef SYNTHESIS
    a_tick_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
        tick_go |=> s1_valid_reg)
        else $error("accepted tick did not reach the read stage");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (s1_valid_reg && res_valid))
        else $error("request stalled with room in the pipeline");

    a_start_loads_play: assert property (@(posedge clk) disable iff (!rst_n)
        (req_acc && (req.req_type == REQ_START)) |=> (playing_reg && !half_reg))
        else $error("start did not begin play in half zero");

    a_wrap_to_half_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_go && tick_wrap && half_reg) |=> (!half_reg && (ptr_reg <= PTR_W'(1))))
        else $error("swap to half zero left pointer off the half start");
`endif

endmodule

FILE: tb/tb_pwm_audio_double_buffer_player_core.sv
// Self-checking testbench for the PWM audio double-buffer player core.
module tb_pwm_audio_double_buffer_player_core;
    import pap_pkg::*;

    localparam int HALF        = HALF_BYTES_DEF;
    localparam int STORE_BYTES = 2 * HALF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 1730;
    localparam int SETTLE_CYCLES = 4;
    localparam int ZERO_COUNT_TICKS = 40;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    req_item_t             req;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    res_item_t             res;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pwm_audio_double_buffer_player_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Player image: store, pointer, count, half, play state and registers
    logic [SAMPLE_W-1:0]      store_img [0:STORE_BYTES-1];
    bit                       written   [0:STORE_BYTES-1];
    logic [WR_ADDR_W-1:0]     ptr_r;
    logic [TICK_W-1:0]        ticks_r;
    logic                     half_r;
    logic                     playing_r;
    logic                     stereo_r;
    logic [SAMPLE_W-1:0]      sign_fix_r;
    logic [1:0]               sample_bytes_r;
    logic [SKIP_W-1:0]        skip_r;
    logic [DUTY_W-1:0]        period_r;
    logic [WR_ADDR_W-1:0]     offset_r;
    logic [START_BYTES_W-1:0] total_r;

    res_item_t duty_queue[$];
    bit        idle_on;
    int        stall_left;
    int        cycle_count;
    int        items_done;
    int        results_checked;
    int        refills_seen;
    int        bad_results;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, duty_queue.size());
            $display("FAIL");
            $finish;
        end
    end

    // Receiver stalls in bursts while idling is on
    always @(negedge clk)
    begin
        if (!rst_n || !idle_on)
        begin
            stall_left = 0;
            res_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            res_stall <= 1'b1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 9) - 1;
            res_stall <= 1'b1;
        end
        else
            res_stall <= 1'b0;
    end

    task automatic note_mismatch(input string what, input res_item_t want, input res_item_t got);
        bad_results++;
        if (bad_results <= 10)
        begin
            $display("mismatch (%s) at cycle %0d: expected L=%0d R=%0d refill=%0b half=%0b",
                     what, cycle_count, want.left_duty, want.right_duty, want.refill_now,
                     want.half_to_fill);
            $display("    got L=%0d R=%0d refill=%0b half=%0b",
                     got.left_duty, got.right_duty, got.refill_now, got.half_to_fill);
        end
    endtask

    always @(posedge clk)
    begin : check_duties
        res_item_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (duty_queue.size() == 0)
                note_mismatch("unexpected item", '0, res);
            else
            begin
                want = duty_queue.pop_front();
                results_checked++;
                if (want.refill_now)
                    refills_seen++;
                if (res.left_duty !== want.left_duty || res.right_duty !== want.right_duty ||
                    res.refill_now !== want.refill_now || res.half_to_fill !== want.half_to_fill)
                    note_mismatch("field", want, res);
            end
        end
    end

    function automatic int eff_bytes();
        if (sample_bytes_r == 2'd0)
            return 1;
        if (sample_bytes_r == 2'd3)
            return 2;
        return int'(sample_bytes_r);
    endfunction

    function automatic logic [DUTY_W-1:0] duty_for(input logic [SAMPLE_W-1:0] raw);
        int unsigned scale;
        int unsigned v;
        int unsigned floor_val;
        floor_val = DUTY_FLOOR;
        scale = (32'(period_r) > floor_val) ? 32'(period_r) - floor_val : 32'd0;
        v = 32'(raw ^ sign_fix_r);
        return DUTY_W'(floor_val + ((scale * v) >> 8));
    endfunction

    // Apply one accepted item to the player image and queue its duty result
    task automatic advance_player(input req_item_t it);
        res_item_t            r;
        logic [WR_ADDR_W-1:0] rd;
        case (it.req_type)
            REQ_WRITE:
            begin
                store_img[it.write_address] = it.write_data;
                written[it.write_address] = 1'b1;
            end
            REQ_START:
            begin
                half_r = 1'b0;
                ptr_r = offset_r;
                ticks_r = TICK_W'(total_r >> skip_r);
                playing_r = 1'b1;
            end
            REQ_HALT:
                playing_r = 1'b0;
            default:
            begin
                if (playing_r)
                begin
                    r.left_duty = duty_for(store_img[ptr_r]);
                    rd = ptr_r + WR_ADDR_W'(eff_bytes());
                    r.right_duty = stereo_r ? duty_for(store_img[rd]) : r.left_duty;
                    r.refill_now = 1'b0;
                    ptr_r = ptr_r + WR_ADDR_W'(1 << skip_r);
                    ticks_r = ticks_r - TICK_W'(1);
                    if (ticks_r == '0)
                    begin
                        half_r = ~half_r;
                        ptr_r = WR_ADDR_W'(int'(half_r) * HALF + eff_bytes() - 1);
                        ticks_r = TICK_W'(HALF >> skip_r);
                        r.refill_now = 1'b1;
                    end
                    r.half_to_fill = ~half_r;
                    duty_queue.push_back(r);
                end
            end
        endcase
    endtask

    task automatic send_item(input req_item_t it);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            @(negedge clk) req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req <= it;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (it.req_type != REQ_TICK || playing_r)
            items_done++;
        advance_player(it);
    endtask

    function automatic req_item_t rand_item(input logic [1:0] kind);
        req_item_t it;
        it.req_type = kind;
        it.write_address = WR_ADDR_W'($urandom_range(0, STORE_BYTES - 1));
        it.write_data = SAMPLE_W'($urandom_range(0, 255));
        return it;
    endfunction

    task automatic write_byte(input logic [WR_ADDR_W-1:0] addr, input logic [SAMPLE_W-1:0] data);
        req_item_t it;
        it.req_type = REQ_WRITE;
        it.write_address = addr;
        it.write_data = data;
        send_item(it);
    endtask

    // Fill any byte the next tick would read that was never written
    task automatic send_tick();
        logic [WR_ADDR_W-1:0] rd;
        if (playing_r)
        begin
            if (!written[ptr_r])
                write_byte(ptr_r, SAMPLE_W'($urandom_range(0, 255)));
            rd = ptr_r + WR_ADDR_W'(eff_bytes());
            if (stereo_r && !written[rd])
                write_byte(rd, SAMPLE_W'($urandom_range(0, 255)));
        end
        send_item(rand_item(REQ_TICK));
    endtask

    // Hold the sender until every duty result is back and the pipe is empty
    task automatic settle();
        @(negedge clk) req_valid <= 1'b0;
        while (duty_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input int stereo, input int sign_fix, input int sbytes,
                             input int skip, input int period, input int offs, input int total);
        int                   vals[7];
        logic [CFG_IDX_W-1:0] idx;
        settle();
        vals = '{stereo, sign_fix, sbytes, skip, period, offs, total};
        for (int i = 0; i < 7; i++)
        begin
            idx = CFG_IDX_W'(i);
            @(negedge clk);
            cfg_write <= 1'b1;
            cfg_index <= idx;
            cfg_data <= CFG_DATA_W'(vals[i]);
            case (idx)
                CFG_STEREO_MODE:  stereo_r = vals[i][0];
                CFG_SIGN_FIX:     sign_fix_r = SAMPLE_W'(vals[i]);
                CFG_SAMPLE_BYTES: sample_bytes_r = 2'(vals[i]);
                CFG_SKIP_LOG2:    skip_r = SKIP_W'(vals[i]);
                CFG_TIMER_PERIOD: period_r = DUTY_W'(vals[i]);
                CFG_START_OFFSET: offset_r = WR_ADDR_W'(vals[i]);
                CFG_START_BYTES:  total_r = START_BYTES_W'(vals[i]);
                default: ;
            endcase
        end
        @(negedge clk) cfg_write <= 1'b0;
    endtask

    // Ticks before any start are dropped; writes and halts give nothing back
    task automatic test_halted_ticks();
        send_item(rand_item(REQ_TICK));
        send_item(rand_item(REQ_TICK));
        send_item(rand_item(REQ_HALT));
        write_byte(10'd0, 8'h00);
        write_byte(10'd1023, 8'hFF);
        send_item(rand_item(REQ_TICK));
    endtask

    task automatic test_directed_play();
        // Stereo with odd size code, wrap at the store top, swap after three ticks
        configure(1, 8'h80, 3, 0, 65535, 1023, 3);
        send_item(rand_item(REQ_START));
        repeat (4) send_tick();
        send_item(rand_item(REQ_HALT));
        send_item(rand_item(REQ_TICK));
        // Restart goes back to half zero
        send_item(rand_item(REQ_START));
        send_tick();
        // Size code zero, widest skip, period below the floor, full first pass
        configure(1, 0, 0, 7, 29, 0, 1024);
        send_item(rand_item(REQ_START));
        repeat (10) send_tick();
        // Zero first count, period at the floor, all-ones mask
        configure(0, 8'hFF, 1, 2, 30, 512, 0);
        send_item(rand_item(REQ_START));
        repeat (3) send_tick();
        configure(1, 8'h80, 2, 3, 31, 700, 40);
        send_item(rand_item(REQ_START));
        repeat (6) send_tick();
    endtask

    task automatic test_random_play();
        int phase_len;
        int pick;
        int skip;
        int phase;
        req_item_t it;
        items_done = 0;
        phase = 0;
        while (items_done < RANDOM_ITEMS)
        begin
            idle_on = (items_done < RANDOM_ITEMS * 85 / 100) && ($urandom_range(0, 3) != 0);
            skip = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(3, 7);
            pick = $urandom_range(0, 5);
            configure($urandom_range(0, 1),
                      ($urandom_range(0, 2) == 0) ? 8'h80 : $urandom_range(0, 255),
                      $urandom_range(0, 3), skip,
                      (pick == 0) ? 0 : (pick == 1) ? $urandom_range(29, 31) :
                      (pick == 2) ? 65535 : $urandom_range(0, 65535),
                      $urandom_range(0, STORE_BYTES - 1), $urandom_range(0, STORE_BYTES));
            repeat ($urandom_range(0, 20)) send_item(rand_item(REQ_WRITE));
            send_item(rand_item(REQ_START));
            phase_len = $urandom_range(120, 260);
            for (int k = 0; k < phase_len && items_done < RANDOM_ITEMS; k++)
            begin
                if (phase == 2 && k == phase_len / 2)
                    settle();
                pick = $urandom_range(0, 99);
                if (pick < 76)
                    send_tick();
                else if (pick < 90)
                begin
                    // Mostly refill the half that is not playing
                    it = rand_item(REQ_WRITE);
                    if ($urandom_range(0, 2) != 0)
                        it.write_address[WR_ADDR_W-1] = ~half_r;
                    send_item(it);
                end
                else if (pick < 94)
                    send_item(rand_item(REQ_START));
                else if (pick < 96)
                    send_item(rand_item(REQ_HALT));
                else
                begin
                    it = rand_item(2'($urandom_range(0, 3)));
                    if (it.req_type == REQ_TICK)
                        send_tick();
                    else
                        send_item(it);
                end
            end
            phase++;
        end
    endtask

    // A count of zero wraps the 16-bit counter: no swap in the first ticks of the pass
    task automatic test_zero_count_wrap();
        idle_on = 1'b0;
        configure(0, $urandom_range(0, 255), 1, 7, 65535,
                  $urandom_range(0, STORE_BYTES - 1), 100);
        send_item(rand_item(REQ_START));
        repeat (ZERO_COUNT_TICKS) send_tick();
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_on = 1'b1;
        cycle_count = 0;
        results_checked = 0;
        refills_seen = 0;
        bad_results = 0;
        items_done = 0;
        for (int i = 0; i < STORE_BYTES; i++)
        begin
            store_img[i] = '0;
            written[i] = 1'b0;
        end
        ptr_r = '0;
        ticks_r = '0;
        half_r = 1'b0;
        playing_r = 1'b0;
        stereo_r = 1'b0;
        sign_fix_r = '0;
        sample_bytes_r = 2'd1;
        skip_r = '0;
        period_r = '0;
        offset_r = '0;
        total_r = '0;
        repeat (3) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        test_halted_ticks();
        test_directed_play();
        test_random_play();
        test_zero_count_wrap();

        settle();
        repeat (10) @(posedge clk);
        $display("covered writes, starts, halts and ticks over mono, stereo, all skips and sizes");
        $display("checked %0d duty results including %0d half swaps, %0d mismatches",
                 results_checked, refills_seen, bad_results);
        if (bad_results == 0 && duty_queue.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
